// ===== hw/rtl/rgb2nv12_pkg.sv =====
`default_nettype none

package rgb2nv12_pkg;

	// Register indexes on the configuration port
	localparam logic [1:0] RegFrameWidth  = 2'd0;
	localparam logic [1:0] RegFrameHeight = 2'd1;
	localparam logic [1:0] RegBgrOrder    = 2'd2;

	localparam int CfgDataW = 13;
	localparam int SizeW    = 14;
	localparam int RowW     = 12;
	localparam int LumaColW = 12;

	localparam logic [SizeW-1:0] ResetWidth  = 14'd640;
	localparam logic [SizeW-1:0] ResetHeight = 14'd480;
	localparam logic [SizeW-1:0] HeightCap   = 14'd4096;
	localparam logic [SizeW-1:0] MinSize     = 14'd2;

	// BT.601 full-range coefficients
	localparam logic [16:0] CoefYR  = 17'd77;
	localparam logic [16:0] CoefYG  = 17'd150;
	localparam logic [16:0] CoefYB  = 17'd29;
	localparam logic [16:0] CoefCbR = 17'd43;
	localparam logic [16:0] CoefCbG = 17'd85;
	localparam logic [16:0] CoefCrG = 17'd107;
	localparam logic [16:0] CoefCrB = 17'd21;
	localparam logic [16:0] CoefHalf = 17'd128;
	localparam logic [16:0] RoundY   = 17'd128;
	// 32768 keeps the difference non-negative, 128 rounds the shift
	localparam logic [16:0] ChromaBias = 17'd32896;

	// Per-pair sums of one even-row pixel pair
	typedef struct packed {
		logic [8:0] r;
		logic [8:0] g;
		logic [8:0] b;
	} pair_sum_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rgb2nv12_line_mem.sv =====
`default_nettype none

module rgb2nv12_line_mem
	import rgb2nv12_pkg::*;
#(
	parameter int AW = 11
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire pair_sum_t     wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output pair_sum_t          rd_data
);

	pair_sum_t mem [2**AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_planar_to_nv12_converter.sv =====
`default_nettype none

// An accepted pixel passes through stage 1, stage 2 and the output register.
// Throughput: one pixel per cycle unless m_tready stalls; each pixel makes at most
// one line store access (write on even rows, read on odd rows, never on two adjacent pixels).
// Reset: counters, left pixel and pipeline valids clear; sizes return to 640x480 RGB.
// The line store is not cleared; an odd row reads only pairs its even row wrote.
module rgb_planar_to_nv12_converter
	import rgb2nv12_pkg::*;
#(
	parameter int MAX_WIDTH = 4096
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_addr,
	input  wire logic [CfgDataW-1:0] cfg_wdata,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// first_plane_value, second_plane_value, third_plane_value
	input  wire logic [23:0]         s_tdata,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// luma, luma_row, luma_col, chroma_b, chroma_r, chroma_row, chroma_col, zero pad
	output logic [71:0]              m_tdata,
	// chroma_valid
	output logic                     m_tuser,
	// frame_last
	output logic                     m_tlast
);

	localparam int CW   = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH) : 2;
	localparam int AW   = CW - 1;
	localparam int ColW = (CW > LumaColW) ? CW : LumaColW;
	localparam logic [SizeW-1:0] MaxW = SizeW'(MAX_WIDTH);

	// Configuration, stored as effective sizes
	logic [SizeW-1:0] width_q;
	logic [SizeW-1:0] height_q;
	logic             bgr_q;
	logic [SizeW-1:0] eff_w;
	logic [SizeW-1:0] eff_h;

	always_comb begin
		eff_w = SizeW'({cfg_wdata[CfgDataW-1:1], 1'b0});
		eff_h = eff_w;
		if (eff_w == '0) begin
			eff_w = MinSize;
			eff_h = MinSize;
		end
		if (eff_w > MaxW) begin
			eff_w = MaxW;
		end
		if (eff_h > HeightCap) begin
			eff_h = HeightCap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ResetWidth;
			height_q <= ResetHeight;
			bgr_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				RegFrameWidth:  width_q  <= eff_w;
				RegFrameHeight: height_q <= eff_h;
				RegBgrOrder:    bgr_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Pipeline handshake
	logic v_s1, v_s2, out_v_q;
	logic en_out, en_s2, en_s1, acc;

	assign en_out   = !out_v_q || m_tready;
	assign en_s2    = !v_s2 || en_out;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;
	assign acc      = s_tvalid && s_tready;

	// Position counters
	logic [CW-1:0]   col_q;
	logic [RowW-1:0] row_q;
	rgb_t            left_q;
	logic [CW-1:0]   col;
	logic [RowW-1:0] row;
	logic [RowW:0]   row_t;
	logic [RowW:0]   row_nx;
	logic [CW:0]     col_nx;
	logic            wrap_in;
	logic            wrap_out;
	logic            last;
	rgb_t            px;

	always_comb begin
		wrap_in = SizeW'(col_q) >= width_q;
		col     = wrap_in ? '0 : col_q;
		row_t   = wrap_in ? ((RowW+1)'(row_q) + 1'b1) : (RowW+1)'(row_q);
		row     = (SizeW'(row_t) >= height_q) ? '0 : row_t[RowW-1:0];
		col_nx  = (CW+1)'(col) + 1'b1;
		wrap_out = SizeW'(col_nx) >= width_q;
		row_nx  = (RowW+1)'(row) + 1'b1;
		last    = (SizeW'(col_nx) == width_q) && (SizeW'(row_nx) == height_q);
		px.g    = s_tdata[15:8];
		px.r    = bgr_q ? s_tdata[23:16] : s_tdata[7:0];
		px.b    = bgr_q ? s_tdata[7:0] : s_tdata[23:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (acc) begin
			if (!col[0]) begin
				left_q <= px;
			end
			if (wrap_out) begin
				col_q <= '0;
				row_q <= (SizeW'(row_nx) >= height_q) ? '0 : row_nx[RowW-1:0];
			end else begin
				col_q <= col_nx[CW-1:0];
				row_q <= row;
			end
		end
	end

	// Line store: even rows write the pair sums, odd rows read them back
	pair_sum_t wr_sum;
	pair_sum_t rd_sum;
	logic      mem_wr, mem_rd;

	assign wr_sum.r = 9'(left_q.r) + 9'(px.r);
	assign wr_sum.g = 9'(left_q.g) + 9'(px.g);
	assign wr_sum.b = 9'(left_q.b) + 9'(px.b);
	assign mem_wr   = acc && col[0] && !row[0];
	assign mem_rd   = acc && col[0] && row[0];

	rgb2nv12_line_mem #(
		.AW(AW)
	) u_line_mem (
		.clk     (clk),
		.wr_en   (mem_wr),
		.wr_addr (col[CW-1:1]),
		.wr_data (wr_sum),
		.rd_en   (mem_rd),
		.rd_addr (col[CW-1:1]),
		.rd_data (rd_sum)
	);

	// Stage 1: pixel, left pixel and position, aligned with the store read data
	rgb_t                px_s1, left_s1;
	logic [ColW-1:0]     col_s1;
	logic [RowW-1:0]     row_s1;
	logic                chv_s1, last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1   <= px;
			left_s1 <= left_q;
			col_s1  <= ColW'(col);
			row_s1  <= row;
			chv_s1  <= col[0] && row[0];
			last_s1 <= last;
		end
	end

	logic [16:0] luma_sum;
	logic [9:0]  sr, sg, sb;

	always_comb begin
		luma_sum = CoefYR * 17'(px_s1.r) + CoefYG * 17'(px_s1.g)
			+ CoefYB * 17'(px_s1.b) + RoundY;
		sr = 10'(rd_sum.r) + 10'(left_s1.r) + 10'(px_s1.r) + 10'd2;
		sg = 10'(rd_sum.g) + 10'(left_s1.g) + 10'(px_s1.g) + 10'd2;
		sb = 10'(rd_sum.b) + 10'(left_s1.b) + 10'(px_s1.b) + 10'd2;
	end

	// Stage 2: luma and block averages
	logic [7:0]          luma_s2, ar_s2, ag_s2, ab_s2;
	logic [LumaColW-1:0] col_s2;
	logic [RowW-1:0]     row_s2;
	logic                chv_s2, last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			luma_s2 <= luma_sum[16] ? 8'hFF : luma_sum[15:8];
			ar_s2   <= sr[9:2];
			ag_s2   <= sg[9:2];
			ab_s2   <= sb[9:2];
			col_s2  <= col_s1[LumaColW-1:0];
			row_s2  <= row_s1;
			chv_s2  <= chv_s1;
			last_s2 <= last_s1;
		end
	end

	logic [16:0] cb_sum, cr_sum;
	logic [7:0]  cb, cr;
	logic [10:0] crow;
	logic [11:0] ccol;

	always_comb begin
		cb_sum = CoefHalf * 17'(ab_s2) + ChromaBias
			- (CoefCbR * 17'(ar_s2) + CoefCbG * 17'(ag_s2));
		cr_sum = CoefHalf * 17'(ar_s2) + ChromaBias
			- (CoefCrG * 17'(ag_s2) + CoefCrB * 17'(ab_s2));
		cb   = '0;
		cr   = '0;
		crow = '0;
		ccol = '0;
		if (chv_s2) begin
			cb   = cb_sum[16] ? 8'hFF : cb_sum[15:8];
			cr   = cr_sum[16] ? 8'hFF : cr_sum[15:8];
			crow = row_s2[RowW-1:1];
			// odd column, so Cb sits one byte to the left
			ccol = {col_s2[LumaColW-1:1], 1'b0};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_out) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			m_tdata <= {1'b0, ccol, crow, cr, cb, col_s2, row_s2, luma_s2};
			m_tuser <= chv_s2;
			m_tlast <= last_s2;
		end
	end

	assign m_tvalid = out_v_q;

endmodule

`default_nettype wire
